[rtl/core/u8d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CP_W = 31;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [1:0] CLS_ASCII   = 2'd0;
  localparam logic [1:0] CLS_INVALID = 2'd1;
  localparam logic [1:0] CLS_LEAD    = 2'd2;

  // A classified byte. The class, length and lead payload only matter when no
  // continuation is due; otherwise the back end uses the low six bits.
  typedef struct packed {
    logic [1:0] cls;
    logic [2:0] more;
    logic [6:0] bits;
    logic [5:0] low6;
    logic       eos;
  } item_t;

  function automatic item_t classify(input logic [7:0] b, input logic eos);
    item_t it;
    it.cls  = CLS_INVALID;
    it.more = 3'd0;
    it.bits = 7'd0;
    it.low6 = b[5:0];
    it.eos  = eos;
    case (b) inside
      [8'h00:8'h7f]: begin
        it.cls  = CLS_ASCII;
        it.bits = b[6:0];
      end
      [8'hc0:8'hdf]: begin
        it.cls  = CLS_LEAD;
        it.more = 3'd1;
        it.bits = {2'b00, b[4:0]};
      end
      [8'he0:8'hef]: begin
        it.cls  = CLS_LEAD;
        it.more = 3'd2;
        it.bits = {3'b000, b[3:0]};
      end
      [8'hf0:8'hf7]: begin
        it.cls  = CLS_LEAD;
        it.more = 3'd3;
        it.bits = {4'b0000, b[2:0]};
      end
      [8'hf8:8'hfb]: begin
        it.cls  = CLS_LEAD;
        it.more = 3'd4;
        it.bits = {5'b00000, b[1:0]};
      end
      [8'hfc:8'hfd]: begin
        it.cls  = CLS_LEAD;
        it.more = 3'd5;
        it.bits = {6'b000000, b[0]};
      end
      default: begin
        it.cls = CLS_INVALID;
      end
    endcase
    return it;
  endfunction

endpackage
`default_nettype wire

[rtl/core/u8d_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic [1:0]  status;
  logic        last_of_string;

  modport source (output valid, output code_point, output status, output last_of_string,
                  input ready);
  modport sink (input valid, input code_point, input status, input last_of_string,
                output ready);
endinterface
`default_nettype wire

[rtl/core/u8d_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module u8d_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  u8d_in_if.sink              in_s,
  output      u8d_pkg::item_t item_o,
  output      logic           item_valid_o,
  input  wire logic           item_ready_i
);
  import u8d_pkg::*;

  logic  v_r, v_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign in_s.ready = !v_r || item_ready_i;
  assign take       = in_s.valid && in_s.ready;

  always_comb begin
    v_nxt    = v_r;
    item_nxt = item_r;
    if (take) begin
      v_nxt    = 1'b1;
      item_nxt = classify(in_s.in_byte, in_s.end_of_string);
    end else if (item_ready_i) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_o       = item_r;
  assign item_valid_o = v_r;
endmodule
`default_nettype wire

[rtl/core/u8d_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module u8d_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire u8d_pkg::item_t wr_item_i,
  input  wire logic           wr_valid_i,
  output      logic           wr_ready_o,
  output      u8d_pkg::item_t rd_item_o,
  output      logic           rd_valid_o,
  input  wire logic           rd_ready_i
);
  import u8d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready_o = (cnt_r != CW'(DEPTH));
  assign rd_valid_o = (cnt_r != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_item_i;
    end
  end
endmodule
`default_nettype wire

[rtl/core/u8d_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module u8d_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire u8d_pkg::item_t item_i,
  input  wire logic           item_valid_i,
  output      logic           item_ready_o,
  u8d_out_if.source           out_s
);
  import u8d_pkg::*;

  logic [2:0]      pend_r, pend_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            ov_r, ov_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic [1:0]      st_r, st_nxt;
  logic            last_r, last_nxt;
  logic            step;
  logic [CP_W-1:0] shifted;
  logic [2:0]      pend_dec;

  // A request may be taken whenever the output register is free or drains now;
  // bytes that give no result simply update the state.
  assign item_ready_o = !ov_r || out_s.ready;
  assign step         = item_valid_i && item_ready_o;
  assign shifted      = {part_r[CP_W-7:0], item_i.low6};
  assign pend_dec     = pend_r - 3'd1;

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    ov_nxt   = ov_r && !out_s.ready;
    cp_nxt   = cp_r;
    st_nxt   = st_r;
    last_nxt = last_r;
    if (step) begin
      if (pend_r == 3'd0) begin
        case (item_i.cls)
          CLS_ASCII: begin
            ov_nxt   = 1'b1;
            cp_nxt   = CP_W'(item_i.bits);
            st_nxt   = ST_OK;
            last_nxt = item_i.eos;
          end
          CLS_LEAD: begin
            if (item_i.eos) begin
              ov_nxt   = 1'b1;
              cp_nxt   = '0;
              st_nxt   = ST_TRUNC;
              last_nxt = 1'b1;
            end else begin
              pend_nxt = item_i.more;
              part_nxt = CP_W'(item_i.bits);
            end
          end
          default: begin
            ov_nxt   = 1'b1;
            cp_nxt   = '0;
            st_nxt   = ST_INVALID;
            last_nxt = item_i.eos;
          end
        endcase
      end else if (pend_dec == 3'd0) begin
        pend_nxt = 3'd0;
        part_nxt = '0;
        ov_nxt   = 1'b1;
        cp_nxt   = shifted;
        st_nxt   = ST_OK;
        last_nxt = item_i.eos;
      end else if (item_i.eos) begin
        pend_nxt = 3'd0;
        part_nxt = '0;
        ov_nxt   = 1'b1;
        cp_nxt   = '0;
        st_nxt   = ST_TRUNC;
        last_nxt = 1'b1;
      end else begin
        pend_nxt = pend_dec;
        part_nxt = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
      part_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      ov_r   <= ov_nxt;
    end
    cp_r   <= cp_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign out_s.valid          = ov_r;
  assign out_s.code_point     = cp_r;
  assign out_s.status         = st_r;
  assign out_s.last_of_string = last_r;
endmodule
`default_nettype wire

[rtl/core/utf8_stream_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// Decodes a byte stream in the original six-byte UTF-8 form into 31-bit code
// points, one byte per request. The block takes one byte every cycle for as
// long as the result side keeps up; a byte passes through the classifying
// register, the queue and the output register before its result appears.
// The queue of QUEUE_DEPTH entries lets the input side keep going while the
// result side stalls. Lead bytes and middle continuation bytes give no
// result unless they end the string; stray continuation bytes and 0xFE/0xFF
// are reported as invalid and dropped. No clearing pass is needed after reset.
module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  u8d_in_if.sink     in_chan,
  u8d_out_if.source  out_chan
);
  import u8d_pkg::*;

  item_t f_item, q_item;
  logic  f_valid, f_ready, q_valid, q_ready;

  u8d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_s         (in_chan),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_item_i  (f_item),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .rd_item_o  (q_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready)
  );

  u8d_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .out_s        (out_chan)
  );
endmodule
`default_nettype wire

[sim/tb_utf8_stream_decoder.sv]
`timescale 1ns / 1ps
module tb_utf8_stream_decoder;
  import u8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 1100;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [1:0]      status;
    logic            last;
  } decoded_char_t;

  // Follows the decoder's state byte by byte and keeps the characters it
  // should produce, oldest first.
  class code_point_tracker;
    logic [2:0]      conts_due;
    logic [CP_W-1:0] partial_cp;
    decoded_char_t   pending_chars[$];

    function new();
      conts_due  = 3'd0;
      partial_cp = '0;
    endfunction

    function void push_char(logic [CP_W-1:0] cp, logic [1:0] st, logic last);
      decoded_char_t c;
      c.code_point = cp;
      c.status     = st;
      c.last       = last;
      pending_chars.push_back(c);
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      logic [2:0]      more;
      logic [CP_W-1:0] lead_bits;
      more      = 3'd0;
      lead_bits = '0;
      if (conts_due == 3'd0) begin
        casez (b)
          8'b0???????: push_char({24'd0, b[6:0]}, ST_OK, eos);
          8'b10??????, 8'b1111111?: push_char('0, ST_INVALID, eos);
          8'b110?????: begin
            more      = 3'd1;
            lead_bits = {26'd0, b[4:0]};
          end
          8'b1110????: begin
            more      = 3'd2;
            lead_bits = {27'd0, b[3:0]};
          end
          8'b11110???: begin
            more      = 3'd3;
            lead_bits = {28'd0, b[2:0]};
          end
          8'b111110??: begin
            more      = 3'd4;
            lead_bits = {29'd0, b[1:0]};
          end
          default: begin
            more      = 3'd5;
            lead_bits = {30'd0, b[0]};
          end
        endcase
        if (more != 3'd0) begin
          if (eos) begin
            push_char('0, ST_TRUNC, 1'b1);
          end else begin
            conts_due  = more;
            partial_cp = lead_bits;
          end
        end
      end else begin
        // Whatever its top bits, a byte that arrives while continuations are
        // due contributes its low six bits.
        partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
        conts_due  = conts_due - 3'd1;
        if (conts_due == 3'd0) begin
          push_char(partial_cp, ST_OK, eos);
          partial_cp = '0;
        end else if (eos) begin
          push_char('0, ST_TRUNC, 1'b1);
          conts_due  = 3'd0;
          partial_cp = '0;
        end
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction

    // Returns an empty string when the result is the one expected.
    function string check_result(logic [CP_W-1:0] cp, logic [1:0] st, logic last);
      decoded_char_t want;
      string         msg;
      msg = "";
      if (pending_chars.size() == 0)
        return $sformatf("unexpected result code_point=%0h status=%0d last=%0b", cp, st, last);
      want = pending_chars.pop_front();
      if (cp !== want.code_point)
        msg = {msg, $sformatf(" code_point %0h, wanted %0h;", cp, want.code_point)};
      if (st !== want.status)
        msg = {msg, $sformatf(" status %0d, wanted %0d;", st, want.status)};
      if (last !== want.last)
        msg = {msg, $sformatf(" last_of_string %0b, wanted %0b;", last, want.last)};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_count = 0;
  int mismatch_count = 0;
  int sent_count = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  code_point_tracker tracker = new();

  // Bit 8 flags the last byte of a string.
  logic [8:0] directed_bytes[$] = '{
    9'h000, 9'h17f,                           // ASCII extremes
    9'h080, 9'h1bf, 9'h0fe, 9'h0ff,           // stray continuations and 0xFE/0xFF
    9'h0df, 9'h0bf,                           // largest two-byte value
    9'h0ef, 9'h0ff, 9'h000,                   // continuations with wrong top bits
    9'h0fd, 9'h0bf, 9'h0bf, 9'h0bf, 9'h0bf, 9'h1bf, // largest six-byte value
    9'h1f8,                                   // string ends on a lead byte
    9'h0f4, 9'h180,                           // string ends mid-sequence
    9'h0c0, 9'h180                            // overlong zero ending a string
  };

  u8d_in_if  in_chan ();
  u8d_out_if out_chan ();

  utf8_stream_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("cycle %0d: bad result:%s", cycle_count, what);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.in_byte       <= b;
    in_chan.end_of_string <= eos;
    do @(posedge clk); while (!in_chan.ready);
    tracker.note_byte(b, eos);
    sent_count++;
  endtask

  // Mostly well-formed characters of every length, with stray bytes, bad
  // continuation bytes and cut-short sequences mixed in.
  task automatic send_random_string();
    logic [8:0]  string_bytes[$];
    logic [7:0]  bv;
    logic [31:0] payload;
    int n_chars;
    int kind;
    int n_cont;
    int keep;
    n_chars = $urandom_range(1, 10);
    for (int c = 0; c < n_chars; c++) begin
      kind    = $urandom_range(0, 15);
      payload = $urandom;
      if (kind < 6) begin
        bv = {1'b0, payload[6:0]};
        string_bytes.push_back({1'b0, bv});
      end else if (kind < 14) begin
        n_cont = $urandom_range(1, 5);
        case (n_cont)
          1:       bv = {3'b110, payload[4:0]};
          2:       bv = {4'b1110, payload[3:0]};
          3:       bv = {5'b11110, payload[2:0]};
          4:       bv = {6'b111110, payload[1:0]};
          default: bv = {7'b1111110, payload[0]};
        endcase
        string_bytes.push_back({1'b0, bv});
        keep = n_cont;
        if ($urandom_range(0, 9) == 0)
          keep = $urandom_range(0, n_cont - 1);
        for (int k = 0; k < keep; k++) begin
          payload = $urandom;
          if ($urandom_range(0, 11) == 0)
            bv = payload[7:0];
          else
            bv = {2'b10, payload[5:0]};
          string_bytes.push_back({1'b0, bv});
        end
      end else if (kind == 14) begin
        bv = {2'b10, payload[5:0]};
        string_bytes.push_back({1'b0, bv});
      end else begin
        bv = {7'b1111111, payload[0]};
        string_bytes.push_back({1'b0, bv});
      end
    end
    string_bytes[string_bytes.size() - 1][8] = 1'b1;
    in_calm = ($urandom_range(0, 3) == 0);
    foreach (string_bytes[i])
      send_byte(string_bytes[i][7:0], string_bytes[i][8]);
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.in_byte       <= 8'h00;
    in_chan.end_of_string <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_bytes[i])
      send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    while (sent_count < RANDOM_BYTES + directed_bytes.size())
      send_random_string();
    in_chan.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    // Leave room for any stray result still inside the pipeline.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    int    gap;
    string msg;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      msg = tracker.check_result(out_chan.code_point, out_chan.status,
                                 out_chan.last_of_string);
      if (msg != "")
        report_mismatch(msg);
      if ($urandom_range(0, 31) == 0)
        out_calm = !out_calm;
    end
  end

endmodule
